/* hdl/sgp_pkg.sv */
// Shared types, codes and constants of the shelf glyph packer.
package sgp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_GLYPH_DIM   = 255;

    localparam logic [12:0] ATLAS_WIDTH_RESET  = 13'd1024;
    localparam logic [12:0] ATLAS_HEIGHT_RESET = 13'd1024;
    localparam logic [3:0]  PAD_RESET          = 4'd2;
    localparam logic [23:0] PIXEL_RGB_WHITE    = 24'hFF_FFFF;

    localparam logic [1:0] CMD_RESET = 2'd0;
    localparam logic [1:0] CMD_PLACE = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    typedef enum logic [1:0] {
        CFG_ATLAS_WIDTH  = 2'd0,
        CFG_ATLAS_HEIGHT = 2'd1,
        CFG_PAD          = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_RESET  = 2'd0,
        OP_PLACE  = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_IGNORE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_PLACE      = 2'd0,
        KIND_PIXEL      = 2'd1,
        KIND_RESET_DONE = 2'd2,
        KIND_IGNORED    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] glyph_width;
        logic [7:0] glyph_height;
        logic [7:0] coverage;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [25:0] byte_address;
        logic [31:0] pixel_word;
    } t_out_word;

    typedef struct packed {
        logic [12:0] atlas_width;
        logic [12:0] atlas_height;
        logic [3:0]  pad;
    } t_cfg;

    // Classified word handed from the front to the back.
    typedef struct packed {
        t_op        op;
        logic       empty;
        logic       oversize;
        logic [7:0] glyph_width;
        logic [7:0] glyph_height;
        logic [7:0] coverage;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* hdl/sgp_front.sv */
// Front end: input handshake and classification of each incoming word.
module sgp_front
    import sgp_pkg::*;
(
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    input  t_q_status i_q_status,
    output logic      o_in_ready,
    output logic      o_push,
    output t_task     o_task
);

    localparam logic [9:0] MaxDim = 10'(MAX_GLYPH_DIM);

    t_op w_op;

    always_comb begin
        unique case (i_in_word.cmd)
            CMD_RESET: w_op = OP_RESET;
            CMD_PLACE: w_op = OP_PLACE;
            CMD_PIXEL: w_op = OP_PIXEL;
            CMD_NONE:  w_op = OP_IGNORE;
        endcase
    end

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    always_comb begin
        o_task.op           = w_op;
        o_task.empty        = (i_in_word.glyph_width == 8'd0) ||
                              (i_in_word.glyph_height == 8'd0);
        o_task.oversize     = ({2'b00, i_in_word.glyph_width} > MaxDim) ||
                              ({2'b00, i_in_word.glyph_height} > MaxDim);
        o_task.glyph_width  = i_in_word.glyph_width;
        o_task.glyph_height = i_in_word.glyph_height;
        o_task.coverage     = i_in_word.coverage;
    end

endmodule

/* hdl/sgp_queue.sv */
// Short FIFO of classified words between the front and the back.
module sgp_queue
    import sgp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_task     i_task,
    input  logic      i_pop,
    output logic      o_valid,
    output t_task     o_task,
    output t_q_status o_status
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LastSlot = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] Depth    = CW'(QUEUE_DEPTH);

    t_task         r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_push, w_pop;

    assign w_pop  = i_pop && (r_count != '0);
    assign w_push = i_push && (r_count != Depth);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == LastSlot) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == LastSlot) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_task;
        end
    end

    assign o_valid        = (r_count != '0);
    assign o_task         = r_slot[r_rd];
    assign o_status.full  = (r_count == Depth);
    assign o_status.empty = (r_count == '0);

endmodule

/* hdl/sgp_back.sv */
// Back end: shelf packer and blit state, address multiply and output register.
module sgp_back
    import sgp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_task_valid,
    input  t_task     i_task,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // Result of the state step, waiting for the address multiply.
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [12:0] pix_x;
        logic [12:0] pix_y;
        logic [7:0]  coverage;
    } t_step;

    logic [12:0] r_pen_x, n_pen_x;
    logic [12:0] r_pen_y, n_pen_y;
    logic [8:0]  r_shelf, n_shelf;
    logic [11:0] r_org_x, n_org_x;
    logic [11:0] r_org_y, n_org_y;
    logic [7:0]  r_col, n_col;
    logic [7:0]  r_row, n_row;
    logic [7:0]  r_blit_w, n_blit_w;
    logic [7:0]  r_blit_h, n_blit_h;
    logic        r_active, n_active;

    logic        r_step_valid;
    t_step       r_step, n_step;
    logic        r_out_valid;
    t_out_word   r_out;

    logic        w_out_adv, w_step_adv;
    logic [9:0]  w_box_w, w_box_h;
    logic        w_wrap, w_fit_y, w_too_wide;
    logic [12:0] w_pen_x, w_pen_y;
    logic [8:0]  w_shelf;
    logic [11:0] w_ox, w_oy;
    logic        w_last_col, w_last_row;
    logic [25:0] w_prod;
    logic [23:0] w_lin;

    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_step_adv = !r_step_valid || w_out_adv;
    assign o_pop      = i_task_valid && w_step_adv;

    // Padded box and the shelf decision.
    always_comb begin
        w_box_w    = {2'b00, i_task.glyph_width} + {5'b0, i_cfg.pad, 1'b0};
        w_box_h    = {2'b00, i_task.glyph_height} + {5'b0, i_cfg.pad, 1'b0};
        w_too_wide = i_task.oversize || ({3'b0, w_box_w} > i_cfg.atlas_width);
        w_wrap     = ({1'b0, r_pen_x} + {4'b0, w_box_w}) > {1'b0, i_cfg.atlas_width};
        w_pen_x    = w_wrap ? {9'b0, i_cfg.pad} : r_pen_x;
        w_pen_y    = w_wrap ? (r_pen_y + {4'b0, r_shelf}) : r_pen_y;
        w_shelf    = w_wrap ? 9'd0 : r_shelf;
        w_fit_y    = ({1'b0, w_pen_y} + {4'b0, w_box_h}) <= {1'b0, i_cfg.atlas_height};
        w_ox       = w_pen_x[11:0] + {8'b0, i_cfg.pad};
        w_oy       = w_pen_y[11:0] + {8'b0, i_cfg.pad};
        w_last_col = ({1'b0, r_col} + 9'd1) >= {1'b0, r_blit_w};
        w_last_row = ({1'b0, r_row} + 9'd1) >= {1'b0, r_blit_h};
    end

    always_comb begin
        n_pen_x  = r_pen_x;
        n_pen_y  = r_pen_y;
        n_shelf  = r_shelf;
        n_org_x  = r_org_x;
        n_org_y  = r_org_y;
        n_col    = r_col;
        n_row    = r_row;
        n_blit_w = r_blit_w;
        n_blit_h = r_blit_h;
        n_active = r_active;
        n_step   = '0;
        unique case (i_task.op)
            OP_RESET: begin
                n_pen_x     = {9'b0, i_cfg.pad};
                n_pen_y     = {9'b0, i_cfg.pad};
                n_shelf     = '0;
                n_active    = 1'b0;
                n_step.kind = KIND_RESET_DONE;
            end
            OP_PLACE: begin
                n_active    = 1'b0;
                n_step.kind = KIND_PLACE;
                if (i_task.empty) begin
                    n_step.status = ST_EMPTY;
                end else if (w_too_wide) begin
                    n_step.status = ST_REFUSED;
                end else begin
                    // A new shelf stays even when the box is then refused at the bottom.
                    n_pen_x = w_pen_x;
                    n_pen_y = w_pen_y;
                    n_shelf = w_shelf;
                    if (!w_fit_y) begin
                        n_step.status = ST_REFUSED;
                    end else begin
                        n_org_x       = w_ox;
                        n_org_y       = w_oy;
                        n_col         = '0;
                        n_row         = '0;
                        n_blit_w      = i_task.glyph_width;
                        n_blit_h      = i_task.glyph_height;
                        n_active      = 1'b1;
                        n_pen_x       = w_pen_x + {3'b0, w_box_w};
                        n_shelf       = ({1'b0, w_box_h} > {2'b0, w_shelf}) ?
                                        w_box_h[8:0] : w_shelf;
                        n_step.status = ST_PLACED;
                        n_step.pos_x  = w_ox;
                        n_step.pos_y  = w_oy;
                    end
                end
            end
            OP_PIXEL: begin
                if (!r_active) begin
                    n_step.kind = KIND_IGNORED;
                end else begin
                    n_step.kind     = KIND_PIXEL;
                    n_step.pix_x    = {1'b0, r_org_x} + {5'b0, r_col};
                    n_step.pix_y    = {1'b0, r_org_y} + {5'b0, r_row};
                    n_step.coverage = i_task.coverage;
                    if (w_last_col) begin
                        n_col = '0;
                        if (w_last_row) begin
                            n_row    = '0;
                            n_active = 1'b0;
                        end else begin
                            n_row = r_row + 8'd1;
                        end
                    end else begin
                        n_col = r_col + 8'd1;
                    end
                end
            end
            OP_IGNORE: begin
                n_step.kind = KIND_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x      <= {9'b0, PAD_RESET};
            r_pen_y      <= {9'b0, PAD_RESET};
            r_shelf      <= '0;
            r_org_x      <= '0;
            r_org_y      <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_blit_w     <= '0;
            r_blit_h     <= '0;
            r_active     <= 1'b0;
            r_step_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pen_x  <= n_pen_x;
                r_pen_y  <= n_pen_y;
                r_shelf  <= n_shelf;
                r_org_x  <= n_org_x;
                r_org_y  <= n_org_y;
                r_col    <= n_col;
                r_row    <= n_row;
                r_blit_w <= n_blit_w;
                r_blit_h <= n_blit_h;
                r_active <= n_active;
            end
            if (w_step_adv) begin
                r_step_valid <= i_task_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_step <= n_step;
        end
    end

    // Only the low 24 bits of the pixel index survive the byte scaling.
    assign w_prod = r_step.pix_y * i_cfg.atlas_width;
    assign w_lin  = w_prod[23:0] + {11'b0, r_step.pix_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_step_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_step_valid) begin
            r_out.kind   <= r_step.kind;
            r_out.status <= r_step.status;
            r_out.pos_x  <= r_step.pos_x;
            r_out.pos_y  <= r_step.pos_y;
            if (r_step.kind == KIND_PIXEL) begin
                r_out.byte_address <= {w_lin, 2'b00};
                r_out.pixel_word   <= {r_step.coverage, PIXEL_RGB_WHITE};
            end else begin
                r_out.byte_address <= '0;
                r_out.pixel_word   <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

/* hdl/shelf_glyph_packer_blit_unit.sv */
// An accepted input word passes through the queue, the step register and the output register.
// Throughput: one word per cycle while the result side is ready; the packer state updates
// once per word, and the pixel address multiply sits in the following stage.
// Reset (synchronous, active low) empties the queue and pipeline, sets the pen
// to the reset padding, clears the shelf and blit state and reloads the config.
module shelf_glyph_packer_blit_unit
    import sgp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word
);

    t_cfg      r_cfg;
    t_q_status w_q_status;
    logic      w_push, w_pop, w_task_valid;
    t_task     w_push_task, w_task;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.atlas_width  <= ATLAS_WIDTH_RESET;
            r_cfg.atlas_height <= ATLAS_HEIGHT_RESET;
            r_cfg.pad          <= PAD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATLAS_WIDTH:  r_cfg.atlas_width  <= i_cfg_data;
                CFG_ATLAS_HEIGHT: r_cfg.atlas_height <= i_cfg_data;
                CFG_PAD:          r_cfg.pad          <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    sgp_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_q_status (w_q_status),
        .o_in_ready (o_in_ready),
        .o_push     (w_push),
        .o_task     (w_push_task)
    );

    sgp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_task   (w_push_task),
        .i_pop    (w_pop),
        .o_valid  (w_task_valid),
        .o_task   (w_task),
        .o_status (w_q_status)
    );

    sgp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_task_valid (w_task_valid),
        .i_task       (w_task),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue reports full and empty at once");

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("back end popped an empty queue");

    a_non_pixel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.kind != KIND_PIXEL)) |->
        ((o_out_word.byte_address == '0) && (o_out_word.pixel_word == '0)))
        else $error("non-pixel word carries pixel fields");

    a_refused_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.kind == KIND_PLACE) &&
         (o_out_word.status != ST_PLACED)) |->
        ((o_out_word.pos_x == '0) && (o_out_word.pos_y == '0)))
        else $error("unplaced glyph reports a position");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the shelf glyph packer with its pixel write stream.
module tb_top;
    import sgp_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TAIL_ITEMS   = 250;
    localparam int SETTLE_TICKS = 6;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_word   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_word;

    // Packer state as the testbench predicts it.
    logic [12:0] atlas_w, atlas_h;
    logic [3:0]  pad_px;
    logic [12:0] pen_x, pen_y;
    logic [8:0]  shelf_h;
    logic [11:0] org_x, org_y;
    logic [7:0]  blit_col, blit_row, blit_w, blit_h;
    logic        blit_on;

    t_out_word awaited_words[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        items_sent     = 0;
    int        stall_left     = 0;
    int        quiet_left     = 0;
    bit        gaps_on        = 1'b0;

    shelf_glyph_packer_blit_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side back-pressure: short stall bursts between quiet stretches.
    always @(posedge i_clk) begin
        if (!gaps_on) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (quiet_left > 0) begin
            quiet_left  <= quiet_left - 1;
            i_out_ready <= 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
            quiet_left  <= $urandom_range(20, 80);
            i_out_ready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: kind %0d status %0d pos %0d,%0d addr %h pix %h",
                             o_out_word.kind, o_out_word.status, o_out_word.pos_x,
                             o_out_word.pos_y, o_out_word.byte_address,
                             o_out_word.pixel_word);
            end else begin
                want = awaited_words.pop_front();
                if (o_out_word !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp: kind %0d status %0d pos %0d,%0d addr %h pix %h",
                                 want.kind, want.status, want.pos_x, want.pos_y,
                                 want.byte_address, want.pixel_word);
                        $display("         got: kind %0d status %0d pos %0d,%0d addr %h pix %h",
                                 o_out_word.kind, o_out_word.status, o_out_word.pos_x,
                                 o_out_word.pos_y, o_out_word.byte_address,
                                 o_out_word.pixel_word);
                    end
                end
            end
        end
    end

    function automatic t_in_word mk(input logic [1:0] cmd, input logic [7:0] gw,
                                    input logic [7:0] gh, input logic [7:0] cov);
        t_in_word w;
        w.cmd          = cmd;
        w.glyph_width  = gw;
        w.glyph_height = gh;
        w.coverage     = cov;
        return w;
    endfunction

    function automatic logic [12:0] pick_dim();
        case ($urandom_range(0, 5))
            0:       return 13'd1;
            1:       return 13'd4096;
            2:       return 13'($urandom_range(1, 4096));
            default: return 13'($urandom_range(8, 160));
        endcase
    endfunction

    // Works out the result word of one accepted input word and updates the packer state.
    task automatic packer_step(input t_in_word w);
        t_out_word        r;
        int unsigned      bw, bh;
        longint unsigned  px, py, addr;
        r = '0;
        case (w.cmd)
            CMD_RESET: begin
                pen_x   = 13'(pad_px);
                pen_y   = 13'(pad_px);
                shelf_h = '0;
                blit_on = 1'b0;
                r.kind  = KIND_RESET_DONE;
            end
            CMD_PLACE: begin
                blit_on = 1'b0;
                r.kind  = KIND_PLACE;
                bw = int'(w.glyph_width) + 2 * int'(pad_px);
                bh = int'(w.glyph_height) + 2 * int'(pad_px);
                if (w.glyph_width == 0 || w.glyph_height == 0) begin
                    r.status = ST_EMPTY;
                end else if (w.glyph_width > MAX_GLYPH_DIM || w.glyph_height > MAX_GLYPH_DIM
                             || bw > atlas_w) begin
                    r.status = ST_REFUSED;
                end else begin
                    // A shelf change stays in effect even when the bottom check refuses.
                    if (pen_x + bw > atlas_w) begin
                        pen_x   = 13'(pad_px);
                        pen_y   = pen_y + 13'(shelf_h);
                        shelf_h = '0;
                    end
                    if (pen_y + bh > atlas_h) begin
                        r.status = ST_REFUSED;
                    end else begin
                        org_x    = 12'(pen_x + pad_px);
                        org_y    = 12'(pen_y + pad_px);
                        blit_col = '0;
                        blit_row = '0;
                        blit_w   = w.glyph_width;
                        blit_h   = w.glyph_height;
                        blit_on  = 1'b1;
                        pen_x    = 13'(pen_x + bw);
                        if (bh > shelf_h)
                            shelf_h = 9'(bh);
                        r.status = ST_PLACED;
                        r.pos_x  = org_x;
                        r.pos_y  = org_y;
                    end
                end
            end
            CMD_PIXEL: begin
                if (!blit_on) begin
                    r.kind = KIND_IGNORED;
                end else begin
                    px   = org_x + blit_col;
                    py   = org_y + blit_row;
                    addr = (py * atlas_w + px) * 4;
                    r.kind         = KIND_PIXEL;
                    r.byte_address = addr[25:0];
                    r.pixel_word   = {w.coverage, PIXEL_RGB_WHITE};
                    if (blit_col + 1 >= blit_w) begin
                        blit_col = '0;
                        if (blit_row + 1 >= blit_h) begin
                            blit_row = '0;
                            blit_on  = 1'b0;
                        end else begin
                            blit_row = blit_row + 8'd1;
                        end
                    end else begin
                        blit_col = blit_col + 8'd1;
                    end
                end
            end
            default: r.kind = KIND_IGNORED;
        endcase
        awaited_words = {awaited_words, r};
    endtask

    task automatic send_word(input t_in_word w);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        packer_step(w);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [12:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ATLAS_WIDTH:  atlas_w = val;
            CFG_ATLAS_HEIGHT: atlas_h = val;
            default:          pad_px  = val[3:0];
        endcase
    endtask

    task automatic set_atlas(input logic [12:0] w, input logic [12:0] h, input logic [3:0] p);
        write_reg(CFG_ATLAS_WIDTH, w);
        write_reg(CFG_ATLAS_HEIGHT, h);
        write_reg(CFG_PAD, 13'(p));
    endtask

    // Places a glyph and, if it landed, streams its coverage bytes (sometimes cut short).
    task automatic send_glyph(input logic [7:0] gw, input logic [7:0] gh);
        int n;
        send_word(mk(CMD_PLACE, gw, gh, 8'($urandom)));
        if (blit_on) begin
            n = int'(gw) * int'(gh);
            if (n > 64)
                n = $urandom_range(1, 40);
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(0, n);
            repeat (n) send_word(mk(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom)));
        end
    endtask

    task automatic test_directed();
        send_word(mk(CMD_RESET, 8'd0, 8'd0, 8'd0));
        send_word(mk(CMD_PLACE, 8'd0, 8'd9, 8'd0));
        send_word(mk(CMD_PLACE, 8'd9, 8'd0, 8'd0));
        send_word(mk(CMD_PIXEL, 8'd0, 8'd0, 8'hA5));
        send_word(mk(CMD_NONE, 8'hFF, 8'hFF, 8'hFF));
        send_word(mk(CMD_PLACE, 8'd255, 8'd255, 8'd0));
        send_word(mk(CMD_PIXEL, 8'd0, 8'd0, 8'h00));
        send_word(mk(CMD_PIXEL, 8'd0, 8'd0, 8'hFF));
        // A new placement drops the unfinished blit of the large glyph.
        send_word(mk(CMD_PLACE, 8'd2, 8'd2, 8'd0));
        repeat (5) send_word(mk(CMD_PIXEL, 8'd0, 8'd0, 8'($urandom)));

        set_atlas(13'd20, 13'd12, 4'd0);
        send_word(mk(CMD_RESET, 8'd0, 8'd0, 8'd0));
        send_word(mk(CMD_PLACE, 8'd21, 8'd1, 8'd0));
        send_word(mk(CMD_PLACE, 8'd20, 8'd1, 8'd0));
        send_word(mk(CMD_PLACE, 8'd5, 8'd5, 8'd0));
        // Wraps to a new shelf and is then refused at the bottom edge.
        send_word(mk(CMD_PLACE, 8'd16, 8'd8, 8'd0));
        send_word(mk(CMD_PLACE, 8'd3, 8'd3, 8'd0));

        set_atlas(13'd4096, 13'd4096, 4'd15);
        send_word(mk(CMD_RESET, 8'd0, 8'd0, 8'd0));
        send_word(mk(CMD_PLACE, 8'd255, 8'd255, 8'd0));
        send_word(mk(CMD_PIXEL, 8'd0, 8'd0, 8'h80));

        set_atlas(13'd1, 13'd1, 4'd0);
        send_word(mk(CMD_RESET, 8'd0, 8'd0, 8'd0));
        send_word(mk(CMD_PLACE, 8'd1, 8'd1, 8'd0));
        send_word(mk(CMD_PIXEL, 8'd0, 8'd0, 8'h01));
        send_word(mk(CMD_PLACE, 8'd2, 8'd1, 8'd0));
        send_word(mk(CMD_PLACE, 8'd1, 8'd1, 8'd0));
    endtask

    task automatic test_random_phases(input int n_items);
        int goal, phase_end;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            set_atlas(pick_dim(), pick_dim(), 4'($urandom_range(0, 15)));
            send_word(mk(CMD_RESET, 8'($urandom), 8'($urandom), 8'($urandom)));
            phase_end = items_sent + $urandom_range(100, 200);
            while (items_sent < phase_end && items_sent < goal) begin
                if ($urandom_range(0, 9) < 8) begin
                    if ($urandom_range(0, 7) == 0)
                        send_glyph(8'($urandom), 8'($urandom));
                    else
                        send_glyph(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
                end else begin
                    send_word(mk(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                                 8'($urandom)));
                end
            end
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        int goal;
        goal = items_sent + n_items;
        gaps_on = 1'b0;
        set_atlas(13'd256, 13'd256, 4'd1);
        send_word(mk(CMD_RESET, 8'd0, 8'd0, 8'd0));
        while (items_sent < goal)
            send_glyph(8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)));
    endtask

    initial begin
        atlas_w  = ATLAS_WIDTH_RESET;
        atlas_h  = ATLAS_HEIGHT_RESET;
        pad_px   = PAD_RESET;
        pen_x    = 13'(PAD_RESET);
        pen_y    = 13'(PAD_RESET);
        shelf_h  = '0;
        org_x    = '0;
        org_y    = '0;
        blit_col = '0;
        blit_row = '0;
        blit_w   = '0;
        blit_h   = '0;
        blit_on  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on = 1'b1;

        test_directed();
        test_random_phases(RANDOM_ITEMS);
        test_back_to_back(TAIL_ITEMS);
        drain();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
